// File: rtl/ghash_pkg.sv
// Shared definitions for the GHASH authenticator: item mode codes, widths
// and the GF(2^128) multiply and byte-mask functions.
// Depends on nothing.
`default_nettype none

package ghash_pkg;

    localparam int WORD_W  = 64;
    localparam int BLOCK_W = 128;
    localparam int BYTES   = 16;
    localparam int COUNT_W = 5;

    typedef logic [WORD_W-1:0]  word_t;
    typedef logic [BLOCK_W-1:0] block_t;

    typedef enum logic [1:0] {
        MODE_AAD    = 2'd0,
        MODE_TEXT   = 2'd1,
        MODE_FINISH = 2'd2,
        MODE_RSVD   = 2'd3
    } mode_t;

    typedef enum logic {
        REG_KEY_HI = 1'b0,
        REG_KEY_LO = 1'b1
    } reg_index_t;

    // Keeps the leading count bytes of a big-endian block; a count of 16 or more keeps all sixteen.
    function automatic block_t lead_mask(input logic [COUNT_W-1:0] count);
        block_t m;
        int     b;
        for (b = 0; b < BYTES; b++)
        begin
            m[BLOCK_W-1-8*b -: 8] = (COUNT_W'(b) < count) ? 8'hff : 8'h00;
        end
        return m;
    endfunction

    // GF(2^128) product in GCM bit order. Bit 0 of the block string (the MSB)
    // is the coefficient of x^0, so both operands are reflected first, then
    // multiplied carry-less and reduced by x^128 + x^7 + x^2 + x + 1.
    function automatic block_t gf_mul(input block_t a, input block_t b);
        logic [BLOCK_W-1:0]   ap;
        logic [BLOCK_W-1:0]   bp;
        logic [2*BLOCK_W-2:0] prod;
        logic [BLOCK_W-2:0]   high;
        logic [BLOCK_W+5:0]   fold;
        logic [5:0]           over;
        logic [12:0]          fold2;
        logic [BLOCK_W-1:0]   r;
        block_t               result;
        int                   i;
        int                   k;
        for (i = 0; i < BLOCK_W; i++)
        begin
            ap[i] = a[BLOCK_W-1-i];
            bp[i] = b[BLOCK_W-1-i];
        end
        // Each product bit is an independent XOR tree over its partial terms.
        for (k = 0; k < 2*BLOCK_W-1; k++)
        begin
            prod[k] = 1'b0;
            for (i = 0; i < BLOCK_W; i++)
            begin
                if ((k - i >= 0) && (k - i < BLOCK_W))
                begin
                    prod[k] = prod[k] ^ (ap[i] & bp[k-i]);
                end
            end
        end
        high = prod[2*BLOCK_W-2:BLOCK_W];
        fold = {7'b0, high} ^ {6'b0, high, 1'b0} ^ {5'b0, high, 2'b0} ^ {high, 7'b0};
        over = fold[BLOCK_W+5:BLOCK_W];
        fold2 = {7'b0, over} ^ {6'b0, over, 1'b0} ^ {5'b0, over, 2'b0} ^ {over, 7'b0};
        r = prod[BLOCK_W-1:0] ^ fold[BLOCK_W-1:0] ^ {{(BLOCK_W-13){1'b0}}, fold2};
        for (i = 0; i < BLOCK_W; i++)
        begin
            result[BLOCK_W-1-i] = r[i];
        end
        return result;
    endfunction

endpackage

`default_nettype wire

// File: rtl/ghash_authenticator.sv
// GHASH authenticator top level: input register, accumulator update and
// digest output register. Depends on ghash_pkg.
`default_nettype none

// One block is absorbed per clock cycle unless the input is stalled. An accepted
// beat sits in the input register, where a combinational 128-bit carry-less
// multiplier by the hash key updates the accumulator; the accumulator feedback
// through that multiplier sets the rate of one beat per cycle. A finish beat
// folds in the length block, writes the digest register from the input
// register and clears the accumulator and both bit totals. Data beats keep
// flowing while an earlier digest waits; a finish beat waits in the input register
// only while a previous digest is still stalled. Load the key halves while
// no beat is in flight; a key change between beats of one message is taken
// up by the next multiplication.
module ghash_authenticator (
    input  wire logic                    clk,
    input  wire logic                    rst_n,
    input  wire logic                    cfg_write,
    input  wire logic                    cfg_index,
    input  wire logic [63:0]             cfg_data,
    input  wire logic                    item_valid,
    output logic                         item_stall,
    input  wire logic [1:0]              mode,
    input  wire logic [63:0]             data_hi,
    input  wire logic [63:0]             data_lo,
    input  wire logic [4:0]              byte_count,
    output logic                         digest_valid,
    input  wire logic                    digest_stall,
    output logic [63:0]                  digest_hi,
    output logic [63:0]                  digest_lo
);
    import ghash_pkg::*;

    word_t                key_hi_reg;
    word_t                key_lo_reg;
    block_t               acc_reg;
    block_t               acc_next;
    word_t                aad_bits_reg;
    word_t                aad_bits_next;
    word_t                text_bits_reg;
    word_t                text_bits_next;
    logic                 stage_valid_reg;
    mode_t                stage_mode_reg;
    block_t               stage_data_reg;
    logic [COUNT_W-1:0]   stage_count_reg;
    logic                 out_valid_reg;
    logic                 out_valid_next;
    block_t               digest_reg;
    logic                 stage_go;
    logic                 item_fire;
    logic                 emit;
    logic [COUNT_W-1:0]   count_sat;
    block_t               mul_in;
    block_t               mul_out;
    word_t                bit_len;

    // A finish beat may only leave the input register once the digest
    // register is free or being taken this cycle.
    assign stage_go   = stage_valid_reg &&
                        !(stage_mode_reg == MODE_FINISH && out_valid_reg && digest_stall);
    assign item_stall = stage_valid_reg && !stage_go;
    assign item_fire  = item_valid && !item_stall;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            key_hi_reg <= '0;
            key_lo_reg <= '0;
        end
        else if (cfg_write)
        begin
            unique case (reg_index_t'(cfg_index))
                REG_KEY_HI: key_hi_reg <= cfg_data;
                REG_KEY_LO: key_lo_reg <= cfg_data;
                default:    key_hi_reg <= key_hi_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            stage_valid_reg <= 1'b0;
        end
        else if (!item_stall)
        begin
            stage_valid_reg <= item_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (item_fire)
        begin
            stage_mode_reg  <= mode_t'(mode);
            stage_data_reg  <= {data_hi, data_lo};
            stage_count_reg <= byte_count;
        end
    end

    assign count_sat = (stage_count_reg > COUNT_W'(BYTES)) ? COUNT_W'(BYTES) : stage_count_reg;
    assign bit_len   = {{(WORD_W-COUNT_W-3){1'b0}}, count_sat, 3'b000};

    always_comb
    begin
        mul_in         = acc_reg ^ (stage_data_reg & lead_mask(count_sat));
        if (stage_mode_reg == MODE_FINISH)
        begin
            mul_in = acc_reg ^ {aad_bits_reg, text_bits_reg};
        end
    end

    assign mul_out = gf_mul(mul_in, {key_hi_reg, key_lo_reg});

    always_comb
    begin
        acc_next       = acc_reg;
        aad_bits_next  = aad_bits_reg;
        text_bits_next = text_bits_reg;
        emit           = 1'b0;
        if (stage_go)
        begin
            case (stage_mode_reg)
                MODE_AAD:
                begin
                    if (stage_count_reg != '0)
                    begin
                        acc_next      = mul_out;
                        aad_bits_next = aad_bits_reg + bit_len;
                    end
                end
                MODE_TEXT:
                begin
                    if (stage_count_reg != '0)
                    begin
                        acc_next       = mul_out;
                        text_bits_next = text_bits_reg + bit_len;
                    end
                end
                MODE_FINISH:
                begin
                    acc_next       = '0;
                    aad_bits_next  = '0;
                    text_bits_next = '0;
                    emit           = 1'b1;
                end
                default:
                begin
                    acc_next = acc_reg;
                end
            endcase
        end
    end

    assign out_valid_next = emit || (out_valid_reg && digest_stall);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            acc_reg       <= '0;
            aad_bits_reg  <= '0;
            text_bits_reg <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            acc_reg       <= acc_next;
            aad_bits_reg  <= aad_bits_next;
            text_bits_reg <= text_bits_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (emit)
        begin
            digest_reg <= mul_out;
        end
    end

    assign digest_valid = out_valid_reg;
    assign digest_hi    = digest_reg[BLOCK_W-1:WORD_W];
    assign digest_lo    = digest_reg[WORD_W-1:0];

`ifndef SYNTHESIS
    a_finish_clears: assert property (@(posedge clk) disable iff (!rst_n)
        stage_go && stage_mode_reg == MODE_FINISH |=>
            acc_reg == '0 && aad_bits_reg == '0 && text_bits_reg == '0)
        else $error("state not cleared after finish");

    a_stall_needs_stage: assert property (@(posedge clk) disable iff (!rst_n)
        item_stall |-> stage_valid_reg && stage_mode_reg == MODE_FINISH && out_valid_reg)
        else $error("input stalled without a blocked finish");

    a_reserved_no_change: assert property (@(posedge clk) disable iff (!rst_n)
        stage_go && stage_mode_reg == MODE_RSVD |=>
            $stable(acc_reg) && $stable(aad_bits_reg) && $stable(text_bits_reg))
        else $error("reserved mode changed state");

    a_digest_from_finish: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> $past(emit))
        else $error("digest appeared without a finish");
`endif

endmodule

`default_nettype wire

// File: verif/testbench.sv
// Self-checking testbench for the GHASH authenticator: directed and random
// messages with a GF(2^128) predictor and randomized backpressure.
// Depends on ghash_pkg and ghash_authenticator from the rtl folder.
module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    import ghash_pkg::*;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        cfg_write = 1'b0;
    logic        cfg_index = 1'b0;
    logic [63:0] cfg_data = '0;
    logic        item_valid = 1'b0;
    logic        item_stall;
    logic [1:0]  mode = MODE_AAD;
    logic [63:0] data_hi = '0;
    logic [63:0] data_lo = '0;
    logic [4:0]  byte_count = '0;
    logic        digest_valid;
    logic        digest_stall = 1'b0;
    logic [63:0] digest_hi;
    logic [63:0] digest_lo;

    // Shadow copy of the block's state, updated at each accepted beat.
    block_t hash_key = '0;
    block_t ghash_acc = '0;
    word_t  aad_bits = '0;
    word_t  text_bits = '0;
    block_t digest_q[$];

    bit sender_gaps = 1'b0;
    bit reader_stalls = 1'b0;
    int errors = 0;
    int blocks_absorbed = 0;
    int digests_checked = 0;
    int key_loads = 0;
    int stall_left = 0;

    ghash_authenticator DUT (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_write    (cfg_write),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .item_valid   (item_valid),
        .item_stall   (item_stall),
        .mode         (mode),
        .data_hi      (data_hi),
        .data_lo      (data_lo),
        .byte_count   (byte_count),
        .digest_valid (digest_valid),
        .digest_stall (digest_stall),
        .digest_hi    (digest_hi),
        .digest_lo    (digest_lo)
    );

    always
    begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    // Product with the hash key, bit 127 of the vector being the x^0 term.
    function automatic block_t times_hash_key(input block_t x);
        block_t z;
        block_t v;
        int     i;
        z = '0;
        v = hash_key;
        for (i = 0; i < BLOCK_W; i++)
        begin
            if (x[BLOCK_W-1-i])
            begin
                z = z ^ v;
            end
            if (v[0])
            begin
                v = (v >> 1) ^ {8'he1, 120'b0};
            end
            else
            begin
                v = v >> 1;
            end
        end
        return z;
    endfunction

    function automatic void absorb_beat(input mode_t m, input word_t hi, input word_t lo,
                                        input logic [4:0] cnt);
        int     n;
        block_t keep;
        n = int'(cnt);
        if (m == MODE_FINISH)
        begin
            ghash_acc = times_hash_key(ghash_acc ^ {aad_bits, text_bits});
            digest_q.push_back(ghash_acc);
            ghash_acc = '0;
            aad_bits = '0;
            text_bits = '0;
        end
        else if (m != MODE_RSVD && n != 0)
        begin
            if (n > BYTES)
            begin
                n = BYTES;
            end
            keep = '1;
            keep = keep << (8 * (BYTES - n));
            ghash_acc = times_hash_key(ghash_acc ^ ({hi, lo} & keep));
            if (m == MODE_AAD)
            begin
                aad_bits = aad_bits + word_t'(8 * n);
            end
            else
            begin
                text_bits = text_bits + word_t'(8 * n);
            end
            blocks_absorbed++;
        end
    endfunction

    // Random receiver stalls in bursts, started at random while reader stalls are enabled.
    always @(posedge clk)
    begin
        if (stall_left == 0 && reader_stalls && $urandom_range(0, 4) == 0)
        begin
            stall_left = $urandom_range(1, 4);
        end
        if (stall_left > 0)
        begin
            digest_stall <= 1'b1;
            stall_left--;
        end
        else
        begin
            digest_stall <= 1'b0;
        end
    end

    always @(posedge clk)
    begin
        if (rst_n && digest_valid && !digest_stall)
        begin
            if (digest_q.size() == 0)
            begin
                $error("digest beat arrived with none expected: %h %h", digest_hi, digest_lo);
                errors++;
            end
            else
            begin
                if (digest_hi !== digest_q[0][127:64])
                begin
                    $error("digest_hi expected %h actual %h", digest_q[0][127:64], digest_hi);
                    errors++;
                end
                if (digest_lo !== digest_q[0][63:0])
                begin
                    $error("digest_lo expected %h actual %h", digest_q[0][63:0], digest_lo);
                    errors++;
                end
                void'(digest_q.pop_front());
                digests_checked++;
            end
        end
    end

    task automatic send_beat(input mode_t m, input word_t hi, input word_t lo,
                             input logic [4:0] cnt);
        if (sender_gaps && $urandom_range(0, 3) == 0)
        begin
            item_valid <= 1'b0;
            repeat ($urandom_range(1, 4)) @(posedge clk);
        end
        item_valid <= 1'b1;
        mode <= m;
        data_hi <= hi;
        data_lo <= lo;
        byte_count <= cnt;
        @(posedge clk);
        while (item_stall)
        begin
            @(posedge clk);
        end
        absorb_beat(m, hi, lo, cnt);
    endtask

    // Stop sending and let every digest and any data beat still in flight
    // clear the block before the key registers are touched.
    task automatic drain_pipeline();
        item_valid <= 1'b0;
        while (digest_q.size() != 0)
        begin
            @(posedge clk);
        end
        repeat (4) @(posedge clk);
    endtask

    task automatic load_key(input block_t k);
        cfg_write <= 1'b1;
        cfg_index <= REG_KEY_HI;
        cfg_data <= k[127:64];
        @(posedge clk);
        hash_key[127:64] = k[127:64];
        cfg_index <= REG_KEY_LO;
        cfg_data <= k[63:0];
        @(posedge clk);
        hash_key[63:0] = k[63:0];
        cfg_write <= 1'b0;
        key_loads++;
    endtask

    function automatic block_t pick_key();
        case ($urandom_range(0, 7))
            0: return '0;
            1: return '1;
            2: return {64'h8000_0000_0000_0000, 64'h0};
            3: return {64'h0, 64'h1};
            default: return {$urandom, $urandom, $urandom, $urandom};
        endcase
    endfunction

    // Finish right after reset, with the key registers still at zero.
    task automatic test_reset_state();
        send_beat(MODE_FINISH, '1, '1, 5'd31);
        drain_pipeline();
    endtask

    task automatic test_byte_counts();
        load_key({64'h66e9_4bd4_ef8a_2c3b, 64'h884c_fa59_ca34_2b2e});
        send_beat(MODE_AAD, '1, '1, 5'd1);
        send_beat(MODE_TEXT, '1, '1, 5'd7);
        send_beat(MODE_AAD, '1, '1, 5'd8);
        send_beat(MODE_TEXT, '1, '1, 5'd9);
        send_beat(MODE_TEXT, '1, '0, 5'd15);
        send_beat(MODE_TEXT, '0, '1, 5'd16);
        // Zero count and the unused mode must leave the state alone;
        // counts above sixteen saturate.
        send_beat(MODE_AAD, '1, '1, 5'd0);
        send_beat(MODE_RSVD, '1, '1, 5'd16);
        send_beat(MODE_TEXT, '1, '1, 5'd17);
        send_beat(MODE_AAD, '1, '1, 5'd31);
        send_beat(MODE_FINISH, '1, '1, 5'd0);
        send_beat(MODE_FINISH, '0, '0, 5'd16);
    endtask

    task automatic test_interleaved_segments();
        send_beat(MODE_AAD, 64'h0123_4567_89ab_cdef, 64'hfedc_ba98_7654_3210, 5'd16);
        send_beat(MODE_TEXT, 64'h5555_5555_5555_5555, 64'haaaa_aaaa_aaaa_aaaa, 5'd12);
        send_beat(MODE_AAD, 64'h8000_0000_0000_0001, 64'h8000_0000_0000_0001, 5'd3);
        send_beat(MODE_TEXT, 64'hdead_beef_cafe_f00d, 64'h0bad_c0de_1234_5678, 5'd16);
        send_beat(MODE_FINISH, '0, '0, 5'd1);
    endtask

    task automatic test_key_change_mid_message();
        send_beat(MODE_AAD, 64'h1111_2222_3333_4444, 64'h5555_6666_7777_8888, 5'd16);
        drain_pipeline();
        load_key('1);
        send_beat(MODE_TEXT, 64'h9999_aaaa_bbbb_cccc, 64'hdddd_eeee_ffff_0000, 5'd10);
        send_beat(MODE_FINISH, '0, '0, 5'd0);
        drain_pipeline();
        load_key({64'h8000_0000_0000_0000, 64'h0});
    endtask

    task automatic test_random_messages(input int beats_wanted);
        int     counted;
        int     msg_len;
        int     aad_len;
        int     j;
        int     r;
        bit     calm;
        mode_t  m;
        logic [4:0] cnt;
        counted = 0;
        while (counted < beats_wanted)
        begin
            calm = counted > beats_wanted - 300;
            if ($urandom_range(0, 7) == 0)
            begin
                drain_pipeline();
                load_key(pick_key());
            end
            sender_gaps = !calm && $urandom_range(0, 3) != 0;
            reader_stalls = !calm && $urandom_range(0, 3) != 0;
            msg_len = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 2) : $urandom_range(1, 12);
            aad_len = $urandom_range(0, msg_len);
            for (j = 0; j < msg_len; j++)
            begin
                r = $urandom_range(0, 99);
                if ($urandom_range(0, 9) == 0)
                begin
                    m = mode_t'($urandom_range(MODE_AAD, MODE_TEXT));
                end
                else
                begin
                    m = (j < aad_len) ? MODE_AAD : MODE_TEXT;
                end
                if (r < 60)
                begin
                    cnt = 5'd16;
                end
                else if (r < 70)
                begin
                    cnt = 5'($urandom_range(17, 31));
                end
                else
                begin
                    cnt = 5'($urandom_range(1, 15));
                end
                // A few beats are noise the block has to ignore.
                if (r < 3)
                begin
                    m = MODE_RSVD;
                    cnt = 5'($urandom_range(0, 31));
                end
                else if (r < 6)
                begin
                    cnt = 5'd0;
                end
                else
                begin
                    counted++;
                end
                send_beat(m, {$urandom, $urandom}, {$urandom, $urandom}, cnt);
            end
            send_beat(MODE_FINISH, {$urandom, $urandom}, {$urandom, $urandom},
                      5'($urandom_range(0, 31)));
            counted++;
        end
        sender_gaps = 1'b0;
        reader_stalls = 1'b0;
    endtask

    initial
    begin
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_reset_state();
        sender_gaps = 1'b1;
        reader_stalls = 1'b1;
        test_byte_counts();
        test_interleaved_segments();
        test_key_change_mid_message();
        test_random_messages(1700);
        drain_pipeline();
        repeat (10) @(posedge clk);
        $display("Absorbed %0d data blocks and checked %0d digests under %0d key loads.",
                 blocks_absorbed, digests_checked, key_loads);
        if (errors == 0)
        begin
            $display("TB_OK");
        end
        else
        begin
            $display("TB_ERROR");
        end
        $finish;
    end

    initial
    begin
        #5_000_000;
        $display("TB_ERROR");
        $finish;
    end

endmodule
